// File: hw/rtl/pdst_pkg.sv
// Shared types, constants and microcode for the PID deadband/separation/taper block.
`default_nettype none
package pdst_pkg;

  // Field widths
  localparam int PosW   = 24;   // measured, target: Q15.8
  localparam int ErrW   = 25;   // error: Q16.8
  localparam int RegW   = 16;   // configuration registers
  localparam int DriveW = 17;   // drive: signed Q8.8
  localparam int SumW   = 17;   // error sum, clamped to +/-sum_limit (at most 65535)
  localparam int RawW   = 42;   // PID sum of products
  localparam int MagW   = 41;   // magnitude of the PID sum
  localparam int ProdW  = 44;   // shared multiplier product
  localparam int NumW   = 57;   // |raw| * |e| for the taper
  localparam int AddrW  = 3;

  // Register indexes
  localparam logic [AddrW-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [AddrW-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [AddrW-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [AddrW-1:0] REG_DEADBAND   = 3'd3;
  localparam logic [AddrW-1:0] REG_SEPARATION = 3'd4;
  localparam logic [AddrW-1:0] REG_SUM_LIMIT  = 3'd5;
  localparam logic [AddrW-1:0] REG_TAPER_SPAN = 3'd6;
  localparam logic [AddrW-1:0] REG_OUT_LIMIT  = 3'd7;

  // Register reset values
  localparam logic [RegW-1:0] RST_DEADBAND   = 16'd256;
  localparam logic [RegW-1:0] RST_SEPARATION = 16'd3840;
  localparam logic [RegW-1:0] RST_SUM_LIMIT  = 16'd2560;
  localparam logic [RegW-1:0] RST_TAPER_SPAN = 16'd5120;
  localparam logic [RegW-1:0] RST_OUT_LIMIT  = 16'd2560;

  // Datapath operations, one per microcode step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,    // accept a beat, form e and |e|
    OP_SUM,     // update error sum, p <= kp*e
    OP_MUL_I,   // p <= ki*sum, accumulate
    OP_MUL_D,   // p <= kd*(e - prev), accumulate
    OP_ACC,     // last accumulate, prev <= e
    OP_ABS,     // split raw into sign and magnitude
    OP_TLO,     // p <= |e| * |raw| low part
    OP_THI,     // p <= |e| * |raw| high part
    OP_TACC,    // combine partial products
    OP_DINIT,   // divider setup and overflow check
    OP_DSTEP,   // one quotient bit
    OP_TFIN,    // quotient to magnitude
    OP_FLAT,    // magnitude >> 8
    OP_ZERO,    // deadband: zero result
    OP_OUT      // saturate, sign and load output register
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOIN,
    C_DEAD,
    C_FLAT,
    C_MORE,
    C_OBUSY
  } cond_t;

  localparam int PcW = 4;

  // Step addresses
  localparam logic [PcW-1:0] ST_IDLE  = 4'd0;
  localparam logic [PcW-1:0] ST_CHK   = 4'd1;
  localparam logic [PcW-1:0] ST_SUM   = 4'd2;
  localparam logic [PcW-1:0] ST_MULI  = 4'd3;
  localparam logic [PcW-1:0] ST_MULD  = 4'd4;
  localparam logic [PcW-1:0] ST_ACC   = 4'd5;
  localparam logic [PcW-1:0] ST_ABS   = 4'd6;
  localparam logic [PcW-1:0] ST_TLO   = 4'd7;
  localparam logic [PcW-1:0] ST_THI   = 4'd8;
  localparam logic [PcW-1:0] ST_TACC  = 4'd9;
  localparam logic [PcW-1:0] ST_DINIT = 4'd10;
  localparam logic [PcW-1:0] ST_DSTEP = 4'd11;
  localparam logic [PcW-1:0] ST_TFIN  = 4'd12;
  localparam logic [PcW-1:0] ST_FLAT  = 4'd13;
  localparam logic [PcW-1:0] ST_ZERO  = 4'd14;
  localparam logic [PcW-1:0] ST_OUT   = 4'd15;

  typedef struct packed {
    op_t            op;
    cond_t          cond;
    logic [PcW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic no_input;
    logic dead;
    logic flat;
    logic more;
    logic out_busy;
  } flags_t;

  // Control store. A false condition falls through to the next step;
  // the output step wraps to idle.
  function automatic ctrl_t ucode(input logic [PcW-1:0] addr);
    ctrl_t w;
    unique case (addr)
      ST_IDLE:  w = '{OP_TAKE,  C_NOIN,   ST_IDLE};
      ST_CHK:   w = '{OP_NOP,   C_DEAD,   ST_ZERO};
      ST_SUM:   w = '{OP_SUM,   C_NEVER,  ST_IDLE};
      ST_MULI:  w = '{OP_MUL_I, C_NEVER,  ST_IDLE};
      ST_MULD:  w = '{OP_MUL_D, C_NEVER,  ST_IDLE};
      ST_ACC:   w = '{OP_ACC,   C_NEVER,  ST_IDLE};
      ST_ABS:   w = '{OP_ABS,   C_FLAT,   ST_FLAT};
      ST_TLO:   w = '{OP_TLO,   C_NEVER,  ST_IDLE};
      ST_THI:   w = '{OP_THI,   C_NEVER,  ST_IDLE};
      ST_TACC:  w = '{OP_TACC,  C_NEVER,  ST_IDLE};
      ST_DINIT: w = '{OP_DINIT, C_NEVER,  ST_IDLE};
      ST_DSTEP: w = '{OP_DSTEP, C_MORE,   ST_DSTEP};
      ST_TFIN:  w = '{OP_TFIN,  C_ALWAYS, ST_OUT};
      ST_FLAT:  w = '{OP_FLAT,  C_ALWAYS, ST_OUT};
      ST_ZERO:  w = '{OP_ZERO,  C_NEVER,  ST_IDLE};
      ST_OUT:   w = '{OP_OUT,   C_OBUSY,  ST_OUT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pdst_useq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none
module pdst_useq (
  input  logic            clk,
  input  logic            rst,
  input  pdst_pkg::flags_t flags,
  output pdst_pkg::ctrl_t  cw
);
  import pdst_pkg::*;

  logic [PcW-1:0] pc;
  logic [PcW-1:0] pc_next;
  logic           jump;

  assign cw = ucode(pc);

  always_comb begin
    unique case (cw.cond)
      C_NEVER:  jump = 1'b0;
      C_ALWAYS: jump = 1'b1;
      C_NOIN:   jump = flags.no_input;
      C_DEAD:   jump = flags.dead;
      C_FLAT:   jump = flags.flat;
      C_MORE:   jump = flags.more;
      C_OBUSY:  jump = flags.out_busy;
      default:  jump = 1'b0;
    endcase
  end

  // last step wraps to idle
  assign pc_next = jump ? cw.target : pc + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pid_deadband_separation_taper.sv
// Top level: PID position controller with deadband, integral separation and taper.
// From accept to output valid a beat takes one of three paths: deadband, flat
//   (|e| >= taper_span) or taper, plus any wait for the output register to drain.
// One beat at a time: a new beat waits for idle; the 16-step quotient loop of the
//   taper divider and the single shared multiplier set the pace.
// Reset (rst, sync): registers to defaults, zero sum and previous error, output empty.
`default_nettype none
module pid_deadband_separation_taper (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [23:0] measured, [47:24] target
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [16:0] drive, [23:17] zero
);
  import pdst_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [RegW-1:0] gain_p, gain_i, gain_d;
  logic [RegW-1:0] deadband, sep_thr, sum_limit, taper_span, out_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p     <= '0;
      gain_i     <= '0;
      gain_d     <= '0;
      deadband   <= RST_DEADBAND;
      sep_thr    <= RST_SEPARATION;
      sum_limit  <= RST_SUM_LIMIT;
      taper_span <= RST_TAPER_SPAN;
      out_limit  <= RST_OUT_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN_P:     gain_p     <= cfg_data;
        REG_GAIN_I:     gain_i     <= cfg_data;
        REG_GAIN_D:     gain_d     <= cfg_data;
        REG_DEADBAND:   deadband   <= cfg_data;
        REG_SEPARATION: sep_thr    <= cfg_data;
        REG_SUM_LIMIT:  sum_limit  <= cfg_data;
        REG_TAPER_SPAN: taper_span <= cfg_data;
        REG_OUT_LIMIT:  out_limit  <= cfg_data;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  ctrl_t  cw;
  flags_t flags;

  pdst_useq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  logic signed [ErrW-1:0]   err;        // e = target - measured
  logic [ErrW-1:0]          err_mag;    // |e|
  logic signed [SumW-1:0]   esum;       // integral state
  logic signed [ErrW-1:0]   prev_err;   // derivative state
  logic signed [ProdW-1:0]  p;          // product register
  logic signed [RawW-1:0]   acc;        // raw PID sum, Q.16
  logic [MagW-1:0]          mag;        // |raw|, later the result magnitude
  logic                     neg;
  logic [NumW-1:0]          num;        // |raw| * |e|
  logic [RegW-1:0]          rem;        // divider remainder
  logic [RegW-1:0]          qsh;        // dividend bits in, quotient bits out
  logic [3:0]               cnt;
  logic                     sat;        // quotient >= 2^16
  logic signed [DriveW-1:0] out_drive;
  logic                     out_valid;
  logic                     out_busy;

  assign out_busy      = out_valid & ~m_axis_tready;
  assign s_axis_tready = (cw.op == OP_TAKE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_drive};

  // input unpack, error and magnitude
  logic signed [PosW-1:0] meas, targ;
  logic signed [ErrW-1:0] e_in;
  logic [ErrW-1:0]        ae_in;

  assign meas  = s_axis_tdata[23:0];
  assign targ  = s_axis_tdata[47:24];
  assign e_in  = {targ[PosW-1], targ} - {meas[PosW-1], meas};
  // -(-2^24) wraps to the bit pattern of +2^24, which is right as unsigned
  assign ae_in = e_in[ErrW-1] ? ErrW'(-e_in) : e_in;

  // sequencer conditions
  assign flags.no_input = ~s_axis_tvalid;
  assign flags.dead     = err_mag < {9'b0, deadband};
  assign flags.flat     = ~(err_mag < {9'b0, taper_span});
  assign flags.more     = (cnt != 4'd0);
  assign flags.out_busy = out_busy;

  // integral: add below separation, clear at or above, then clamp
  logic signed [25:0]     sum_add, slim26, nslim26;
  logic signed [SumW-1:0] sum_clamped;

  assign slim26  = {10'b0, sum_limit};
  assign nslim26 = -slim26;

  always_comb begin
    if (err_mag < {9'b0, sep_thr}) begin
      sum_add = {{9{esum[SumW-1]}}, esum} + {err[ErrW-1], err};
    end else begin
      sum_add = '0;
    end
    if (sum_add > slim26) begin
      sum_clamped = slim26[SumW-1:0];
    end else if (sum_add < nslim26) begin
      sum_clamped = nslim26[SumW-1:0];
    end else begin
      sum_clamped = sum_add[SumW-1:0];
    end
  end

  // shared multiplier, 17 x 27 signed
  logic signed [16:0]      ma;
  logic signed [26:0]      mb;
  logic signed [ProdW-1:0] prod;
  logic signed [25:0]      de;

  assign de = {err[ErrW-1], err} - {prev_err[ErrW-1], prev_err};

  always_comb begin
    unique case (cw.op)
      OP_SUM: begin
        ma = {gain_p[RegW-1], gain_p};
        mb = {{2{err[ErrW-1]}}, err};
      end
      OP_MUL_I: begin
        ma = {gain_i[RegW-1], gain_i};
        mb = {{10{esum[SumW-1]}}, esum};
      end
      OP_MUL_D: begin
        ma = {gain_d[RegW-1], gain_d};
        mb = {de[25], de};
      end
      OP_TLO: begin
        ma = {1'b0, err_mag[15:0]};
        mb = {1'b0, mag[25:0]};
      end
      OP_THI: begin
        ma = {1'b0, err_mag[15:0]};
        mb = {12'b0, mag[40:26]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  // PID sum sign and magnitude
  logic signed [RawW-1:0] acc_neg;
  assign acc_neg = -acc;

  // restoring divider step: one quotient bit per cycle
  logic [16:0] r17, r17_sub;
  logic        q_bit;
  logic [15:0] rem_next;

  assign r17      = {rem, qsh[15]};
  assign q_bit    = r17 >= {1'b0, taper_span};
  assign r17_sub  = r17 - {1'b0, taper_span};
  assign rem_next = q_bit ? r17_sub[15:0] : r17[15:0];

  // output saturation and sign
  logic [15:0]              lim_mag;
  logic signed [DriveW-1:0] drive_val;

  assign lim_mag   = (mag > {25'b0, out_limit}) ? out_limit : mag[15:0];
  assign drive_val = neg ? DriveW'(-{1'b0, lim_mag}) : {1'b0, lim_mag};

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_TAKE: begin
        if (s_axis_tvalid) begin
          err     <= e_in;
          err_mag <= ae_in;
        end
      end
      OP_SUM: begin
        p   <= prod;
        acc <= '0;
      end
      OP_MUL_I, OP_MUL_D: begin
        p   <= prod;
        acc <= acc + p[RawW-1:0];
      end
      OP_ACC: acc <= acc + p[RawW-1:0];
      OP_ABS: begin
        neg <= acc[RawW-1];
        mag <= acc[RawW-1] ? acc_neg[MagW-1:0] : acc[MagW-1:0];
      end
      OP_TLO: p <= prod;
      OP_THI: begin
        p   <= prod;
        num <= {13'b0, p};
      end
      OP_TACC: num <= num + {p[30:0], 26'b0};
      OP_DINIT: begin
        // floor(num / (span*256)) = floor((num >> 8) / span); >= 2^16 saturates
        sat <= num[56:8] >= {17'b0, taper_span, 16'b0};
        rem <= num[39:24];
        qsh <= num[23:8];
        cnt <= 4'd15;
      end
      OP_DSTEP: begin
        rem <= rem_next;
        qsh <= {qsh[14:0], q_bit};
        cnt <= cnt - 4'd1;
      end
      OP_TFIN: mag <= sat ? {25'b0, 16'hFFFF} : {25'b0, qsh};
      OP_FLAT: mag <= {8'b0, mag[MagW-1:8]};
      OP_ZERO: begin
        mag <= '0;
        neg <= 1'b0;
      end
      OP_OUT: begin
        if (!out_busy) begin
          out_drive <= drive_val;
        end
      end
      default: ;
    endcase
  end

  // controller state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      esum      <= '0;
      prev_err  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cw.op == OP_SUM) begin
        esum <= sum_clamped;
      end
      if (cw.op == OP_ACC) begin
        prev_err <= err;
      end
      if (cw.op == OP_OUT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // one beat at a time: the sequencer leaves idle right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a beat is in flight");

  // a beat inside the deadband leaves the controller state alone
  a_dead_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (cw.cond == C_DEAD && flags.dead) |=> ($stable(esum) && $stable(prev_err)))
    else $error("deadband beat changed controller state");

  // a result appears only out of the output step
  a_valid_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cw.op == OP_OUT))
    else $error("output valid raised outside the output step");

endmodule
`default_nettype wire
